>>> design/sine_even_horner_evaluator_assert.svh
// Assertion macros for the even-polynomial sine evaluator.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef SINE_EVEN_HORNER_EVALUATOR_ASSERT_SVH
`define SINE_EVEN_HORNER_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SEHE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sehe assertion failed");
// Check a property on every clock edge, reset included.
`define SEHE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sehe assertion failed");
`else
`define SEHE_ASSERT(lbl, clk, rst_n, prop)
`define SEHE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/sehe_pkg.sv
// Shared widths, constants and item types of the even-polynomial sine evaluator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sehe_pkg;

    localparam int PHASE_W        = 16;  // signed Q1.15
    localparam int Z_W            = 31;  // unsigned Q1.30, up to 2^30
    localparam int H_W            = 32;  // signed Q.30 root factor
    localparam int G_W            = 34;  // signed Q18.16 Horner accumulator
    localparam int COEF_W         = 32;  // signed Q16.16
    localparam int SINE_W         = 16;  // signed Q1.15
    localparam int PROD_W         = G_W + H_W;
    localparam int COEF_REGS      = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_COEFFS_DEF = 6;

    localparam logic signed [G_W-1:0] G_MAX = {1'b0, {(G_W-1){1'b1}}};
    localparam logic signed [G_W-1:0] G_MIN = {1'b1, {(G_W-1){1'b0}}};

    // 0.25 in Q.30
    localparam logic [Z_W-1:0] QUARTER_Z = 31'h1000_0000;

    localparam logic signed [SINE_W-1:0] SINE_MAX = 16'sh7fff;
    localparam logic signed [SINE_W-1:0] SINE_MIN = 16'sh8000;

    typedef logic signed [COEF_W-1:0] t_coef;

    // One item in flight between the root factor stage and the product stage.
    typedef struct packed {
        logic signed [PHASE_W-1:0] x;
        logic        [Z_W-1:0]     z;
        logic signed [H_W-1:0]     h;
        logic signed [G_W-1:0]     g;
        logic                      sat;
    } t_item;

endpackage

`default_nettype wire

>>> design/sine_even_horner_evaluator.sv
// Top level of the even-polynomial sine evaluator: coefficient registers and stage chain.
// Depends on sehe_pkg, sehe_front, sehe_horner_step, sehe_out and the assertion header.
//
//  channel   direction  payload                                  handshake
//  s_axis    in         tdata[15:0] phase (Q1.15)                tvalid/tready
//  m_axis    out        tdata[15:0] sine_value, tuser[0] sat     tvalid/tready
//  cfg       in         i_cfg_index selects coef_0..coef_5       i_cfg_we, no wait
//
// One phase is accepted per clock while m_axis does not stall; each result passes through
// square, root factor, one stage per Horner step (NUM_COEFFS - 1), product, rounding.
// Each stage holds its own valid bit and moves on when the next one is empty or moving,
// so a stall on m_axis fills bubbles first and drops or repeats nothing.
// Synchronous active-low reset empties the pipeline and clears the coefficients.
`default_nettype none
`include "sine_even_horner_evaluator_assert.svh"

module sine_even_horner_evaluator #(
    parameter int NUM_COEFFS = sehe_pkg::NUM_COEFFS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire  [15:0]                           i_s_axis_tdata,   // [15:0] phase
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    output logic [15:0]                           o_m_axis_tdata,   // [15:0] sine_value
    output logic [0:0]                            o_m_axis_tuser,   // [0] saturated
    input  wire                                   i_cfg_we,
    input  wire  [sehe_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [sehe_pkg::COEF_W-1:0]           i_cfg_wdata
);

    localparam int TOP_CI = NUM_COEFFS - 1;

    sehe_pkg::t_coef    r_coef [sehe_pkg::COEF_REGS];

    logic               w_valid [NUM_COEFFS];
    logic               w_ready [NUM_COEFFS];
    sehe_pkg::t_item    w_item  [NUM_COEFFS];
    sehe_pkg::t_coef    coef_top;
    logic signed [sehe_pkg::SINE_W-1:0] sine;
    logic               sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sehe_pkg::COEF_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we &&
                     (i_cfg_index < sehe_pkg::CFG_IDX_W'(sehe_pkg::COEF_REGS))) begin
            r_coef[i_cfg_index] <= i_cfg_wdata;
        end
    end

    // terms past the register file read as zero
    generate
        if (TOP_CI < sehe_pkg::COEF_REGS) begin : g_top_reg
            assign coef_top = r_coef[TOP_CI];
        end else begin : g_top_zero
            assign coef_top = '0;
        end
    endgenerate

    sehe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_phase    ($signed(i_s_axis_tdata)),
        .i_coef_top (coef_top),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_item     (w_item[0])
    );

    generate
        for (genvar k = 0; k < NUM_COEFFS - 1; k++) begin : g_step
            localparam int CI = NUM_COEFFS - 2 - k;
            sehe_pkg::t_coef step_coef;
            if (CI < sehe_pkg::COEF_REGS) begin : g_reg
                assign step_coef = r_coef[CI];
            end else begin : g_zero
                assign step_coef = '0;
            end
            sehe_horner_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .o_ready (w_ready[k]),
                .i_item  (w_item[k]),
                .i_coef  (step_coef),
                .o_valid (w_valid[k+1]),
                .i_ready (w_ready[k+1]),
                .o_item  (w_item[k+1])
            );
        end
    endgenerate

    sehe_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_COEFFS-1]),
        .o_ready (w_ready[NUM_COEFFS-1]),
        .i_item  (w_item[NUM_COEFFS-1]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sine  (sine),
        .o_sat   (sat)
    );

    assign o_m_axis_tdata = sine;
    assign o_m_axis_tuser = sat;

    // input backpressure only comes from a pipeline full up to the output register
    `SEHE_ASSERT(a_stall_needs_output, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid)
    // a full pipeline that is not drained stays full: input opens only with the sink
    `SEHE_ASSERT(a_full_holds, i_clk, i_rst_n, (!o_s_axis_tready && !i_m_axis_tready) |=> (!o_s_axis_tready || i_m_axis_tready))
    // after reset the output register holds no item
    `SEHE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

`default_nettype wire

>>> design/sehe_front.sv
// Front end: square of the phase, then root factor x*(z - 0.25) and Horner seed.
// Depends on sehe_pkg and the assertion header.
`default_nettype none
`include "sine_even_horner_evaluator_assert.svh"

module sehe_front (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  signed [sehe_pkg::PHASE_W-1:0]   i_phase,
    input  wire  signed [sehe_pkg::COEF_W-1:0]    i_coef_top,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output sehe_pkg::t_item                       o_item
);

    // square stage
    logic                                 r_va;
    logic signed [sehe_pkg::PHASE_W-1:0]  r_xa;
    logic        [sehe_pkg::Z_W-1:0]      r_za;
    // root factor stage
    logic                                 r_vb;
    sehe_pkg::t_item                      r_item_b;

    logic                                 ready_a;
    logic                                 ready_b;
    logic signed [2*sehe_pkg::PHASE_W-1:0] sq;
    logic signed [sehe_pkg::H_W-1:0]      d;
    logic signed [47:0]                   m;
    logic signed [47:0]                   m_rnd;
    sehe_pkg::t_item                      n_item_b;

    assign ready_b = !r_vb || i_ready;
    assign ready_a = !r_va || ready_b;
    assign o_ready = ready_a;

    assign sq = i_phase * i_phase;

    always_comb begin
        d     = $signed({1'b0, r_za}) - $signed({1'b0, sehe_pkg::QUARTER_Z});
        m     = r_xa * d;
        m_rnd = m + 48'sh4000;
        n_item_b.x   = r_xa;
        n_item_b.z   = r_za;
        n_item_b.h   = m_rnd[46:15];
        n_item_b.g   = {{(sehe_pkg::G_W-sehe_pkg::COEF_W){i_coef_top[sehe_pkg::COEF_W-1]}},
                        i_coef_top};
        n_item_b.sat = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (ready_a) begin
                r_va <= i_valid;
            end
            if (ready_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_xa <= i_phase;
            r_za <= sq[sehe_pkg::Z_W-1:0];
        end
        if (ready_b && r_va) begin
            r_item_b <= n_item_b;
        end
    end

    assign o_valid = r_vb;
    assign o_item  = r_item_b;

    // the root factor vanishes at zero and at plus or minus one half
    `SEHE_ASSERT(a_root_zero, i_clk, i_rst_n, (r_vb && (r_item_b.x == 16'sh0000 || r_item_b.x == 16'sh4000 || r_item_b.x == 16'shc000)) |-> (r_item_b.h == '0))

endmodule

`default_nettype wire

>>> design/sehe_horner_step.sv
// One Horner step: g <= sat(round(g*z >> 30) + coef), one register stage.
// Depends on sehe_pkg.
`default_nettype none

module sehe_horner_step (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  sehe_pkg::t_item                     i_item,
    input  wire  signed [sehe_pkg::COEF_W-1:0]  i_coef,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output sehe_pkg::t_item                     o_item
);

    localparam int PW = sehe_pkg::G_W + sehe_pkg::Z_W + 1;

    logic                          r_valid;
    sehe_pkg::t_item               r_item;

    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          prod_rnd;
    logic signed [PW-30:0]         t;
    logic                          sat_hi;
    logic                          sat_lo;
    sehe_pkg::t_item               n_item;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        prod     = i_item.g * $signed({1'b0, i_item.z});
        prod_rnd = prod + PW'(64'sh2000_0000);
        // floor shift by 30, widen by one bit for the coefficient add
        t = {prod_rnd[PW-1], prod_rnd[PW-1:30]}
            + {{(PW-29-sehe_pkg::COEF_W){i_coef[sehe_pkg::COEF_W-1]}}, i_coef};
        sat_hi = !t[PW-30] && (|t[PW-31:sehe_pkg::G_W-1]);
        sat_lo =  t[PW-30] && !(&t[PW-31:sehe_pkg::G_W-1]);
        n_item = i_item;
        if (sat_hi) begin
            n_item.g = sehe_pkg::G_MAX;
        end else if (sat_lo) begin
            n_item.g = sehe_pkg::G_MIN;
        end else begin
            n_item.g = t[sehe_pkg::G_W-1:0];
        end
        n_item.sat = i_item.sat || sat_hi || sat_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> design/sehe_out.sv
// Back end: product g*h, then rounding to Q1.15 with saturation into the output register.
// Depends on sehe_pkg.
`default_nettype none

module sehe_out (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  sehe_pkg::t_item                      i_item,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic signed [sehe_pkg::SINE_W-1:0]   o_sine,
    output logic                                 o_sat
);

    localparam int PW = sehe_pkg::PROD_W;
    localparam int QW = PW - 31;

    // product stage
    logic                                 r_vp;
    logic signed [PW-1:0]                 r_p;
    logic                                 r_sp;
    // output stage
    logic                                 r_vy;
    logic signed [sehe_pkg::SINE_W-1:0]   r_y;
    logic                                 r_sy;

    logic                                 ready_p;
    logic                                 ready_y;
    logic signed [PW-1:0]                 prod;
    logic signed [PW-1:0]                 p_rnd;
    logic signed [QW-1:0]                 q;
    logic                                 sat_hi;
    logic                                 sat_lo;
    logic signed [sehe_pkg::SINE_W-1:0]   n_y;

    assign ready_y = !r_vy || i_ready;
    assign ready_p = !r_vp || ready_y;
    assign o_ready = ready_p;

    assign prod = i_item.g * i_item.h;

    always_comb begin
        p_rnd  = r_p + PW'(64'sh4000_0000);
        q      = p_rnd[PW-1:31];
        sat_hi = !q[QW-1] && (|q[QW-2:sehe_pkg::SINE_W-1]);
        sat_lo =  q[QW-1] && !(&q[QW-2:sehe_pkg::SINE_W-1]);
        if (sat_hi) begin
            n_y = sehe_pkg::SINE_MAX;
        end else if (sat_lo) begin
            n_y = sehe_pkg::SINE_MIN;
        end else begin
            n_y = q[sehe_pkg::SINE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vy <= 1'b0;
        end else begin
            if (ready_p) begin
                r_vp <= i_valid;
            end
            if (ready_y) begin
                r_vy <= r_vp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_p && i_valid) begin
            r_p  <= prod;
            r_sp <= i_item.sat;
        end
        if (ready_y && r_vp) begin
            r_y  <= n_y;
            r_sy <= r_sp || sat_hi || sat_lo;
        end
    end

    assign o_valid = r_vy;
    assign o_sine  = r_y;
    assign o_sat   = r_sy;

endmodule

`default_nettype wire

>>> dv/sine_even_horner_evaluator_tb.sv
// Testbench for sine_even_horner_evaluator: streams phases through the pipeline and checks
// every result against a predictor of the fixed-point Horner arithmetic. Needs only the RTL
// and sehe_pkg; coefficient sets are loaded over the cfg port between batches.
`timescale 1ns / 1ps

module sine_even_horner_evaluator_tb;

    localparam int PHASE_W      = sehe_pkg::PHASE_W;
    localparam int SINE_W       = sehe_pkg::SINE_W;
    localparam int COEF_W       = sehe_pkg::COEF_W;
    localparam int COEF_REGS    = sehe_pkg::COEF_REGS;
    localparam int CFG_IDX_W    = sehe_pkg::CFG_IDX_W;
    localparam int HORNER_TERMS = sehe_pkg::NUM_COEFFS_DEF;
    localparam int PIPE_LAT     = HORNER_TERMS + 3;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    localparam logic signed [127:0] G_MAX       = sehe_pkg::G_MAX;
    localparam logic signed [127:0] G_MIN       = sehe_pkg::G_MIN;
    localparam logic signed [127:0] SINE_MAX    = sehe_pkg::SINE_MAX;
    localparam logic signed [127:0] SINE_MIN    = sehe_pkg::SINE_MIN;
    localparam logic signed [127:0] G_ROUND     = 128'sd536870912;   // half LSB before >>> 30
    localparam logic signed [127:0] H_ROUND     = 128'sd16384;       // half LSB before >>> 15
    localparam logic signed [127:0] Y_ROUND     = 128'sd1073741824;  // half LSB before >>> 31
    localparam logic signed [127:0] QUARTER_Q30 = 128'sd268435456;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [SINE_W-1:0]  sine;
        logic               sat;
    } t_sine_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata = '0;    // [15:0] phase
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [15:0]          o_m_axis_tdata;         // [15:0] sine_value
    logic [0:0]           o_m_axis_tuser;         // [0] saturated
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0]    i_cfg_wdata = '0;

    sehe_pkg::t_coef    coef_shadow [COEF_REGS];
    sehe_pkg::t_coef    coef_plan   [COEF_REGS];
    logic [PHASE_W-1:0] phase_q[$];
    t_sine_result       sine_exp_q[$];

    logic phase_took = 1'b0;
    int   src_gap = 0;
    int   snk_gap = 0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   stall_cycles = 0;
    int   fail_count = 0;
    int   phases_sent = 0;
    int   results_seen = 0;
    int   sat_seen = 0;
    int   cfg_writes = 0;
    int   coef_sets = 0;

    always #4 i_clk = ~i_clk;

    sine_even_horner_evaluator #(
        .NUM_COEFFS (HORNER_TERMS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    function automatic logic signed [127:0] coef_term(input int k);
        logic signed [127:0] c;
        c = '0;
        // terms past the register file read as zero
        if (k < COEF_REGS) c = coef_shadow[k];
        return c;
    endfunction

    function automatic t_sine_result sine_predict(input logic signed [PHASE_W-1:0] x);
        logic signed [127:0] xw, zw, gw, tw, hw, yw;
        t_sine_result        r;
        xw = x;
        zw = xw * xw;
        r.sat = 1'b0;
        gw = coef_term(HORNER_TERMS - 1);
        for (int k = HORNER_TERMS - 2; k >= 0; k--) begin
            tw = ((gw * zw + G_ROUND) >>> 30) + coef_term(k);
            if (tw > G_MAX) begin
                tw = G_MAX;
                r.sat = 1'b1;
            end else if (tw < G_MIN) begin
                tw = G_MIN;
                r.sat = 1'b1;
            end
            gw = tw;
        end
        hw = (xw * (zw - QUARTER_Q30) + H_ROUND) >>> 15;
        yw = (gw * hw + Y_ROUND) >>> 31;
        if (yw > SINE_MAX) begin
            yw = SINE_MAX;
            r.sat = 1'b1;
        end else if (yw < SINE_MIN) begin
            yw = SINE_MIN;
            r.sat = 1'b1;
        end
        r.phase = x;
        r.sine  = yw[SINE_W-1:0];
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] pick_phase();
        int r;
        logic [PHASE_W-1:0] p;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            // fitted range, -0.5 to 0.5
            p = 16'($urandom_range(0, 32768) - 16384);
        end else if (r < 94) begin
            p = 16'($urandom);
        end else begin
            case ($urandom_range(0, 5))
                0:       p = 16'h8000;
                1:       p = 16'h7fff;
                2:       p = 16'h0000;
                3:       p = 16'h4000;
                4:       p = 16'hc000;
                default: p = 16'hffff;
            endcase
        end
        return p;
    endfunction

    // Source side: hold the item until taken, else idle in bursts or present the next phase.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !phase_took) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (src_gap != 0) begin
            src_gap <= src_gap - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (phase_q.size() == 0) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            src_gap <= $urandom_range(0, 16);
            i_s_axis_tvalid <= 1'b0;
        end else begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= phase_q.pop_front();
        end
    end

    // Sink side: back-pressure in bursts of random length.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap <= snk_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
            snk_gap <= $urandom_range(0, 16);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sine_result want;
        logic         got_one;
        phase_took = 1'b0;
        got_one = 1'b0;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                phase_took = 1'b1;
                sine_exp_q.push_back(sine_predict(i_s_axis_tdata));
                phases_sent++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_one = 1'b1;
                results_seen++;
                if (sine_exp_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result: sine %h sat %b",
                                 o_m_axis_tdata, o_m_axis_tuser);
                end else begin
                    want = sine_exp_q.pop_front();
                    if (want.sat) sat_seen++;
                    if (o_m_axis_tdata !== want.sine || o_m_axis_tuser[0] !== want.sat) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("mismatch phase %h: sine exp %h got %h, sat exp %b got %b",
                                     want.phase, want.sine, o_m_axis_tdata,
                                     want.sat, o_m_axis_tuser);
                    end
                end
            end
        end
        if (phase_took || got_one) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input sehe_pkg::t_coef val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx < COEF_REGS) coef_shadow[idx] = val;
        cfg_writes++;
    endtask

    // Write the planned set, plus the two unused indexes, which must be ignored.
    task automatic commit_plan();
        for (int i = 0; i < COEF_REGS; i++) write_reg(CFG_IDX_W'(i), coef_plan[i]);
        write_reg(CFG_IDX_SPARE_A, sehe_pkg::t_coef'($urandom));
        write_reg(CFG_IDX_SPARE_B, sehe_pkg::t_coef'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        coef_sets++;
    endtask

    // Wait until every phase has gone in and every result has come back, then let the
    // pipeline settle before touching the coefficients.
    task automatic drain_pipe();
        while (phase_q.size() != 0 || i_s_axis_tvalid || sine_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) phase_q.push_back(pick_phase());
        drain_pipe();
    endtask

    task automatic plan_fit();
        // rough fit of sin(2*pi*x) / (x*(x*x - 0.25)) in Q16.16
        coef_plan[0] = -32'sd1647116;
        coef_plan[1] =  32'sd4249091;
        coef_plan[2] = -32'sd4395893;
        coef_plan[3] =  32'sd2524447;
        coef_plan[4] = -32'sd927334;
        coef_plan[5] =  32'sd247726;
    endtask

    task automatic plan_fill(input int mode);
        for (int i = 0; i < COEF_REGS; i++) begin
            case (mode)
                0: coef_plan[i] = 32'sh7fffffff;
                1: coef_plan[i] = 32'sh80000000;
                2: coef_plan[i] = (i % 2 == 0) ? 32'sh7fffffff : 32'sh80000000;
                3: coef_plan[i] = '0;
                4: coef_plan[i] = sehe_pkg::t_coef'($urandom);
                default: coef_plan[i] = sehe_pkg::t_coef'($urandom_range(0, 2097152))
                                        - 32'sd1048576;
            endcase
        end
    endtask

    initial begin
        logic [PHASE_W-1:0] edge_phases [$];
        for (int i = 0; i < COEF_REGS; i++) coef_shadow[i] = '0;
        edge_phases = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h4000,
                        16'hc000, 16'h3fff, 16'h4001, 16'hbfff, 16'hc001, 16'h2000,
                        16'he000, 16'h1000, 16'h6000, 16'ha000, 16'h5555, 16'haaaa,
                        16'h0100, 16'hff00};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients are zero: every result must be zero
        src_idle_pct = 20;
        snk_idle_pct = 20;
        for (int i = 0; i < 4; i++) phase_q.push_back(edge_phases[i + 2]);
        drain_pipe();

        plan_fit();
        commit_plan();
        foreach (edge_phases[i]) phase_q.push_back(edge_phases[i]);
        drain_pipe();
        run_random(180);

        // saturating sets at the coefficient extremes
        for (int mode = 0; mode < 3; mode++) begin
            plan_fill(mode);
            commit_plan();
            src_idle_pct = (mode == 1) ? 0 : 15;
            snk_idle_pct = (mode == 2) ? 0 : 25;
            run_random(150);
        end

        plan_fill(3);
        commit_plan();
        run_random(80);

        src_idle_pct = 10;
        snk_idle_pct = 35;
        for (int k = 0; k < 2; k++) begin
            plan_fill(4);
            commit_plan();
            run_random(125);
        end
        for (int k = 0; k < 3; k++) begin
            plan_fill(5);
            commit_plan();
            run_random(100);
        end

        // closing stretch at full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        plan_fit();
        commit_plan();
        run_random(300);

        if (sine_exp_q.size() != 0) fail_count++;
        $display("sent %0d phases over %0d coefficient sets (%0d register writes)",
                 phases_sent, coef_sets, cfg_writes);
        $display("checked %0d results, %0d of them saturated, %0d failures",
                 results_seen, sat_seen, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
